// ----- design/button_debounce_fsm_assert.svh -----
// assertion macros shared by the debounce design files
`ifndef BUTTON_DEBOUNCE_FSM_ASSERT_SVH
`define BUTTON_DEBOUNCE_FSM_ASSERT_SVH

`ifndef NO_ASSERTIONS

// clocked check, quiet while reset is asserted
`define BDF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// clocked check of a condition followed by a result in the next cycle
`define BDF_ASSERT_NEXT(lbl, cond, res, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (res)) \
		else $error(msg);

`else

`define BDF_ASSERT(lbl, prop, msg)
`define BDF_ASSERT_NEXT(lbl, cond, res, msg)

`endif

`endif

// ----- design/bdf_pkg.sv -----
// types and constants of the button debounce machine
package bdf_pkg;

	localparam int unsigned CountWidth = 8;

	localparam logic [CountWidth-1:0] ThresholdReset = 8'd200;

	// machine states, encoding 7 is unused and acts as unknown
	typedef enum logic [2:0] {
		ST_UNKNOWN  = 3'd0,
		ST_UNK_HIGH = 3'd1,
		ST_UNK_LOW  = 3'd2,
		ST_HIGH     = 3'd3,
		ST_LOW      = 3'd4,
		ST_HIGH_LOW = 3'd5,
		ST_LOW_HIGH = 3'd6
	} dbnc_state_t;

	// one sample handed to the machine
	typedef struct packed {
		logic fire;
		logic raw_level;
	} dbnc_step_t;

	// one result item
	typedef struct packed {
		logic debounced_level;
		logic level_known;
		logic changed_pulse;
		logic rose_pulse;
		logic fell_pulse;
	} dbnc_result_t;

endpackage

// ----- design/bdf_if.sv -----
// handshake channels of the button debounce block

// raw sample channel
interface bdf_sample_if;
	logic valid;
	logic ready;
	logic raw_level;

	modport source (output valid, output raw_level, input ready);
	modport sink (input valid, input raw_level, output ready);
endinterface

// debounced result channel
interface bdf_result_if;
	logic valid;
	logic ready;
	logic debounced_level;
	logic level_known;
	logic changed_pulse;
	logic rose_pulse;
	logic fell_pulse;

	modport source (output valid, output debounced_level, output level_known,
		output changed_pulse, output rose_pulse, output fell_pulse, input ready);
	modport sink (input valid, input debounced_level, input level_known,
		input changed_pulse, input rose_pulse, input fell_pulse, output ready);
endinterface

// threshold write channel
interface bdf_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] confirm_threshold;

	modport source (output valid, output confirm_threshold, input ready);
	modport sink (input valid, input confirm_threshold, output ready);
endinterface

// ----- design/bdf_fsm.sv -----
// debounce state machine with its confirmation counter
`include "button_debounce_fsm_assert.svh"

module bdf_fsm (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  bdf_pkg::dbnc_step_t                  step,
	input  logic [bdf_pkg::CountWidth-1:0]       threshold,
	output bdf_pkg::dbnc_result_t                result
);

	bdf_pkg::dbnc_state_t                state_q;
	bdf_pkg::dbnc_state_t                state_d;
	logic [bdf_pkg::CountWidth-1:0]      count_q;
	logic [bdf_pkg::CountWidth-1:0]      count_d;
	logic                                done;

	// compare before the increment
	assign done = count_q > threshold;

	// next state and counter
	always_comb begin
		state_d = state_q;
		count_d = count_q;
		case (state_q)
			bdf_pkg::ST_HIGH: begin
				if (!step.raw_level) begin
					state_d = bdf_pkg::ST_HIGH_LOW;
					count_d = '0;
				end
			end
			bdf_pkg::ST_LOW: begin
				if (step.raw_level) begin
					state_d = bdf_pkg::ST_LOW_HIGH;
					count_d = '0;
				end
			end
			bdf_pkg::ST_HIGH_LOW: begin
				if (step.raw_level) begin
					state_d = bdf_pkg::ST_HIGH;
				end else begin
					count_d = count_q + 1'b1;
					if (done) state_d = bdf_pkg::ST_LOW;
				end
			end
			bdf_pkg::ST_LOW_HIGH: begin
				if (!step.raw_level) begin
					state_d = bdf_pkg::ST_LOW;
				end else begin
					count_d = count_q + 1'b1;
					if (done) state_d = bdf_pkg::ST_HIGH;
				end
			end
			bdf_pkg::ST_UNK_HIGH: begin
				if (!step.raw_level) begin
					state_d = bdf_pkg::ST_UNKNOWN;
				end else begin
					count_d = count_q + 1'b1;
					if (done) state_d = bdf_pkg::ST_HIGH;
				end
			end
			bdf_pkg::ST_UNK_LOW: begin
				if (step.raw_level) begin
					state_d = bdf_pkg::ST_UNKNOWN;
				end else begin
					count_d = count_q + 1'b1;
					if (done) state_d = bdf_pkg::ST_LOW;
				end
			end
			default: begin
				state_d = step.raw_level ? bdf_pkg::ST_UNK_HIGH : bdf_pkg::ST_UNK_LOW;
				count_d = '0;
			end
		endcase
	end

	// result flags for this sample
	always_comb begin
		result = '0;
		case (state_q)
			bdf_pkg::ST_HIGH_LOW: begin
				if (!step.raw_level && done) begin
					result.changed_pulse = 1'b1;
					result.fell_pulse    = 1'b1;
				end
			end
			bdf_pkg::ST_LOW_HIGH: begin
				if (step.raw_level && done) begin
					result.changed_pulse = 1'b1;
					result.rose_pulse    = 1'b1;
				end
			end
			bdf_pkg::ST_UNK_HIGH: begin
				if (step.raw_level && done) result.changed_pulse = 1'b1;
			end
			bdf_pkg::ST_UNK_LOW: begin
				if (!step.raw_level && done) result.changed_pulse = 1'b1;
			end
			default: begin
				result.changed_pulse = 1'b0;
			end
		endcase
		result.debounced_level = (state_d == bdf_pkg::ST_HIGH) ||
			(state_d == bdf_pkg::ST_HIGH_LOW);
		result.level_known = (state_d == bdf_pkg::ST_HIGH) || (state_d == bdf_pkg::ST_LOW) ||
			(state_d == bdf_pkg::ST_HIGH_LOW) || (state_d == bdf_pkg::ST_LOW_HIGH);
	end

	// state registers advance only on a sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bdf_pkg::ST_UNKNOWN;
			count_q <= '0;
		end else if (step.fire) begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	`BDF_ASSERT_NEXT(a_hold_idle, !step.fire, $stable(state_q) && $stable(count_q), "state moved without a sample")
	`BDF_ASSERT_NEXT(a_high_drop, step.fire && state_q == bdf_pkg::ST_HIGH && !step.raw_level, state_q == bdf_pkg::ST_HIGH_LOW && count_q == '0, "high to pending low not entered cleanly")
	`BDF_ASSERT_NEXT(a_change_settles, step.fire && result.changed_pulse, state_q == bdf_pkg::ST_HIGH || state_q == bdf_pkg::ST_LOW, "change pulse without a settled level")

endmodule

// ----- design/button_debounce_fsm.sv -----
// top level of the counter based button debouncer
//
//  channel    dir  handshake     payload
//  sample_ch  in   valid/ready   raw_level
//  result_ch  out  valid/ready   debounced_level, level_known, changed/rose/fell pulses
//  cfg_ch     in   valid/ready   confirm_threshold (always ready)
//
// one sample per cycle while results are taken; a result leaves after its sample
// passes the sample register, then the machine update into the result register
// the state and counter update in the same cycle the result is registered
// a stalled result holds the pipe; the sample register still fills behind it
// reset sets the unknown state, a zero count and a threshold of 200
`include "button_debounce_fsm_assert.svh"

module button_debounce_fsm (
	input  logic          clk,
	input  logic          arst_n,
	bdf_sample_if.sink    sample_ch,
	bdf_result_if.source  result_ch,
	bdf_cfg_if.sink       cfg_ch
);

	logic                               valid_s1;
	logic                               raw_s1;
	logic                               valid_s2;
	bdf_pkg::dbnc_result_t              result_s2;
	bdf_pkg::dbnc_result_t              result_next;
	bdf_pkg::dbnc_step_t                step;
	logic [bdf_pkg::CountWidth-1:0]     threshold_q;
	logic                               advance;
	logic                               cfg_write;

	// pipe moves when the result register is free or being drained
	assign advance         = !valid_s2 || result_ch.ready;
	assign sample_ch.ready = !valid_s1 || advance;
	assign cfg_ch.ready    = 1'b1;
	assign cfg_write       = cfg_ch.valid && cfg_ch.ready;

	assign step.fire      = valid_s1 && advance;
	assign step.raw_level = raw_s1;

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= bdf_pkg::ThresholdReset;
		end else if (cfg_write) begin
			threshold_q <= cfg_ch.confirm_threshold;
		end
	end

	// sample register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ch.ready) begin
			valid_s1 <= sample_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_ch.valid && sample_ch.ready) raw_s1 <= sample_ch.raw_level;
	end

	bdf_fsm u_fsm (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.threshold (threshold_q),
		.result    (result_next)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step.fire) result_s2 <= result_next;
	end

	assign result_ch.valid           = valid_s2;
	assign result_ch.debounced_level = result_s2.debounced_level;
	assign result_ch.level_known     = result_s2.level_known;
	assign result_ch.changed_pulse   = result_s2.changed_pulse;
	assign result_ch.rose_pulse      = result_s2.rose_pulse;
	assign result_ch.fell_pulse      = result_s2.fell_pulse;

	`BDF_ASSERT_NEXT(a_s1_held, valid_s1 && !advance, valid_s1 && $stable(raw_s1), "stalled sample lost")
	`BDF_ASSERT_NEXT(a_cfg_taken, cfg_write, threshold_q == $past(cfg_ch.confirm_threshold), "threshold write not taken")
	`BDF_ASSERT_NEXT(a_fire_fills, step.fire, valid_s2, "processed sample left no result")

endmodule

// ----- tb/tb_button_debounce_fsm.sv -----
// self-checking testbench of the button debounce machine with a cycle-free level predictor
module tb_button_debounce_fsm;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned QuietLimit = 2000;
	localparam int unsigned HoldCycles = 250;
	localparam int unsigned DrainCycles = 4;

	logic clk = 1'b0;
	logic arst_n;

	bdf_sample_if sample_ch ();
	bdf_result_if result_ch ();
	bdf_cfg_if    cfg_ch ();

	button_debounce_fsm i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_ch (sample_ch),
		.result_ch (result_ch),
		.cfg_ch    (cfg_ch)
	);

	// predictor state, mirrors the machine after each accepted sample
	bdf_pkg::dbnc_state_t             pred_state;
	logic [bdf_pkg::CountWidth-1:0]   pred_count;
	logic [bdf_pkg::CountWidth-1:0]   pred_threshold;

	// reports still owed by the block, oldest first
	bdf_pkg::dbnc_result_t level_reports_q[$];

	int unsigned err_count = 0;
	int unsigned samples_sent;
	int unsigned reports_checked = 0;
	int unsigned changes_seen = 0;
	int unsigned quiet_cycles = 0;

	// idling and long hold-off control
	bit gaps_on;
	int unsigned rx_hold_asked;
	int unsigned rx_hold_given = 0;
	int unsigned rx_hold_left = 0;

	// clock
	always #6 clk = ~clk;

	// compare-before-increment confirmation, counter wraps at 8 bits
	function automatic bit confirm_sample();
		bit done;
		done = pred_count > pred_threshold;
		pred_count = pred_count + 1'b1;
		return done;
	endfunction

	// advance the predicted machine by one raw sample
	function automatic bdf_pkg::dbnc_result_t debounce_predict(input logic hi);
		bdf_pkg::dbnc_result_t r;
		r = '0;
		case (pred_state)
			bdf_pkg::ST_HIGH: begin
				if (!hi) begin
					pred_state = bdf_pkg::ST_HIGH_LOW;
					pred_count = '0;
				end
			end
			bdf_pkg::ST_LOW: begin
				if (hi) begin
					pred_state = bdf_pkg::ST_LOW_HIGH;
					pred_count = '0;
				end
			end
			bdf_pkg::ST_HIGH_LOW: begin
				if (hi) begin
					pred_state = bdf_pkg::ST_HIGH;
				end else if (confirm_sample()) begin
					pred_state = bdf_pkg::ST_LOW;
					r.fell_pulse = 1'b1;
					r.changed_pulse = 1'b1;
				end
			end
			bdf_pkg::ST_LOW_HIGH: begin
				if (!hi) begin
					pred_state = bdf_pkg::ST_LOW;
				end else if (confirm_sample()) begin
					pred_state = bdf_pkg::ST_HIGH;
					r.rose_pulse = 1'b1;
					r.changed_pulse = 1'b1;
				end
			end
			bdf_pkg::ST_UNK_HIGH: begin
				if (!hi) begin
					pred_state = bdf_pkg::ST_UNKNOWN;
				end else if (confirm_sample()) begin
					pred_state = bdf_pkg::ST_HIGH;
					r.changed_pulse = 1'b1;
				end
			end
			bdf_pkg::ST_UNK_LOW: begin
				if (hi) begin
					pred_state = bdf_pkg::ST_UNKNOWN;
				end else if (confirm_sample()) begin
					pred_state = bdf_pkg::ST_LOW;
					r.changed_pulse = 1'b1;
				end
			end
			default: begin
				if (hi) begin
					pred_state = bdf_pkg::ST_UNK_HIGH;
				end else begin
					pred_state = bdf_pkg::ST_UNK_LOW;
				end
				pred_count = '0;
			end
		endcase
		case (pred_state)
			bdf_pkg::ST_HIGH, bdf_pkg::ST_HIGH_LOW: begin
				r.debounced_level = 1'b1;
				r.level_known = 1'b1;
			end
			bdf_pkg::ST_LOW, bdf_pkg::ST_LOW_HIGH: begin
				r.level_known = 1'b1;
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// one field of a report against its prediction
	function automatic void check_field(input string name, input logic exp_v, input logic got_v);
		if (got_v !== exp_v) begin
			$error("%s: expected %0b, got %0b", name, exp_v, got_v);
			err_count++;
		end
	endfunction

	// result checker, sampled at the rising edge
	always @(posedge clk) begin
		bdf_pkg::dbnc_result_t exp_r;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (level_reports_q.size() == 0) begin
				$error("result item with no sample waiting for it");
				err_count++;
			end else begin
				exp_r = level_reports_q.pop_front();
				check_field("debounced_level", exp_r.debounced_level, result_ch.debounced_level);
				check_field("level_known", exp_r.level_known, result_ch.level_known);
				check_field("changed_pulse", exp_r.changed_pulse, result_ch.changed_pulse);
				check_field("rose_pulse", exp_r.rose_pulse, result_ch.rose_pulse);
				check_field("fell_pulse", exp_r.fell_pulse, result_ch.fell_pulse);
				reports_checked++;
				if (result_ch.changed_pulse === 1'b1) begin
					changes_seen++;
				end
			end
		end
	end

	// receiver: random stalls, plus long hold-offs on request
	always @(negedge clk) begin
		if (rx_hold_left > 0) begin
			result_ch.ready = 1'b0;
			rx_hold_left--;
		end else if (rx_hold_asked != rx_hold_given) begin
			rx_hold_given++;
			rx_hold_left = HoldCycles - 1;
			result_ch.ready = 1'b0;
		end else begin
			result_ch.ready = !(gaps_on && $urandom_range(99) < 27);
		end
	end

	// watchdog on cycles where no channel moves an item
	always @(posedge clk) begin
		if (arst_n) begin
			if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
					(cfg_ch.valid && cfg_ch.ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= QuietLimit) begin
				$display("timeout after %0d quiet cycles", quiet_cycles);
				$display("button_debounce_fsm: mismatch");
				$finish;
			end
		end
	end

	// send one raw sample, entered and left at a falling edge
	task automatic send_sample(input logic lvl);
		while (gaps_on && $urandom_range(99) < 27) begin
			sample_ch.valid = 1'b0;
			sample_ch.raw_level = 1'($urandom_range(1));
			@(negedge clk);
		end
		sample_ch.valid = 1'b1;
		sample_ch.raw_level = lvl;
		@(posedge clk);
		while (!sample_ch.ready) begin
			@(posedge clk);
		end
		level_reports_q.push_back(debounce_predict(lvl));
		samples_sent++;
		@(negedge clk);
	endtask

	// stop offering and wait until every report is in, then let the pipe settle
	task automatic wait_drained();
		sample_ch.valid = 1'b0;
		while (level_reports_q.size() != 0) begin
			@(negedge clk);
		end
		repeat (DrainCycles) @(negedge clk);
	endtask

	// write the threshold while the block is idle
	task automatic write_threshold(input logic [bdf_pkg::CountWidth-1:0] thr);
		wait_drained();
		cfg_ch.valid = 1'b1;
		cfg_ch.confirm_threshold = thr;
		@(posedge clk);
		while (!cfg_ch.ready) begin
			@(posedge clk);
		end
		pred_threshold = thr;
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	task automatic send_run(input logic lvl, input int unsigned n);
		repeat (n) send_sample(lvl);
	endtask

	// first settle from unknown at the reset threshold, after both pending states bounce back
	task automatic test_reset_threshold();
		send_sample(1'b1);
		send_sample(1'b0);
		send_sample(1'b0);
		send_sample(1'b1);
		send_run(1'b1, 205);
	endtask

	// hand-picked edges at the lowest thresholds
	task automatic test_directed();
		write_threshold(8'd0);
		// bounce back to high, then a clean fall
		send_sample(1'b0);
		send_sample(1'b1);
		send_sample(1'b0);
		send_sample(1'b0);
		send_sample(1'b0);
		send_sample(1'b0);
		// bounce back to low, then a clean rise
		send_sample(1'b1);
		send_sample(1'b0);
		send_sample(1'b1);
		send_sample(1'b1);
		send_sample(1'b1);
		send_sample(1'b1);
		write_threshold(8'd1);
		// one short of accepting, then bounce, then accept
		send_sample(1'b0);
		send_sample(1'b0);
		send_sample(1'b0);
		send_sample(1'b1);
		send_run(1'b0, 5);
	endtask

	// bounce bursts then stable runs around the accept length
	task automatic test_random_bounce(input logic [bdf_pkg::CountWidth-1:0] thr,
			input int unsigned n);
		int unsigned start;
		logic lvl;
		write_threshold(thr);
		start = samples_sent;
		lvl = 1'($urandom_range(1));
		while (samples_sent - start < n) begin
			lvl = ~lvl;
			repeat ($urandom_range(4)) send_sample(1'($urandom_range(1)));
			if ($urandom_range(9) != 0) begin
				send_run(lvl, thr + 1 + $urandom_range(5));
			end
		end
	endtask

	// pure noise on the raw input
	task automatic test_noise(input int unsigned n);
		write_threshold(8'($urandom_range(3)));
		repeat (n) send_sample(1'($urandom_range(1)));
	endtask

	// highest threshold, one bounce in the middle of a rise
	task automatic test_extreme_threshold();
		write_threshold(8'd254);
		send_run(1'b0, 262);
		send_run(1'b1, 100);
		send_sample(1'b0);
		send_run(1'b1, 262);
	endtask

	// receiver holds off while the sender keeps offering, then the sender drains, sends with gaps and drains again
	task automatic test_backpressure();
		write_threshold(8'd2);
		gaps_on = 1'b0;
		rx_hold_asked++;
		repeat (80) send_sample($urandom_range(3) != 0);
		wait_drained();
		gaps_on = 1'b1;
		repeat (40) send_sample(1'($urandom_range(1)));
		wait_drained();
	endtask

	// stimulus
	initial begin
		arst_n = 1'b0;
		sample_ch.valid = 1'b0;
		sample_ch.raw_level = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.confirm_threshold = '0;
		gaps_on = 1'b1;
		rx_hold_asked = 0;
		samples_sent = 0;
		pred_state = bdf_pkg::ST_UNKNOWN;
		pred_count = '0;
		pred_threshold = bdf_pkg::ThresholdReset;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		test_reset_threshold();
		test_directed();
		gaps_on = 1'b0;
		test_random_bounce(8'd0, 60);
		gaps_on = 1'b1;
		test_random_bounce(8'd1, 60);
		test_random_bounce(8'd2, 60);
		test_random_bounce(8'd3, 60);
		test_random_bounce(8'd5, 60);
		test_random_bounce(8'($urandom_range(15)), 60);
		test_random_bounce(8'($urandom_range(40)), 80);
		test_random_bounce(8'd9, 60);
		test_noise(100);
		test_backpressure();
		test_extreme_threshold();
		test_random_bounce(8'd0, 40);

		wait_drained();
		repeat (8) @(negedge clk);
		$display("summary: %0d samples sent, %0d results checked, %0d settled changes",
			samples_sent, reports_checked, changes_seen);
		$display("thresholds from 0 to 254 with bounce, noise, stalls and a long receiver hold-off");
		if (err_count == 0 && level_reports_q.size() == 0) begin
			$display("button_debounce_fsm: match");
		end else begin
			$display("button_debounce_fsm: mismatch");
		end
		$finish;
	end

endmodule
